// ===== sv/owm_pkg.sv =====
`timescale 1ns / 1ps
// owm_pkg: shared types, constants and helpers of the one-wire bus master
// no dependencies; used by every module of the block except owm_checker

package owm_pkg;

    // field widths
    localparam int ACTION_W = 3;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 10;
    localparam int BITS_W   = 4;

    // slot timer
    localparam int TIMER_W   = 10;
    localparam int TIMER_MAX = (1 << TIMER_W) - 1;
    localparam int SAT_W     = (LEN_W > TIMER_W) ? LEN_W : TIMER_W;

    // fixed timings, in ticks
    localparam int RECOVERY_TICKS       = 410;
    localparam int PRE_RESET_HIGH_TICKS = 5;

    // queue depths
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
    localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

    typedef logic [LEN_W-1:0]   len_t;
    typedef logic [TIMER_W-1:0] timer_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [BITS_W-1:0]  bits_t;

    localparam bits_t BYTE_BITS = bits_t'(BYTE_W);

    typedef enum logic [ACTION_W-1:0] {
        OP_TICK  = 3'd0,
        OP_RESET = 3'd1,
        OP_WBIT  = 3'd2,
        OP_RBIT  = 3'd3,
        OP_WBYTE = 3'd4,
        OP_RBYTE = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        CFG_W1_LOW    = 3'd0,
        CFG_W1_HIGH   = 3'd1,
        CFG_W0_LOW    = 3'd2,
        CFG_W0_HIGH   = 3'd3,
        CFG_RD_SAMPLE = 3'd4,
        CFG_RD_RECOV  = 3'd5,
        CFG_RST_LOW   = 3'd6,
        CFG_PRES_WAIT = 3'd7
    } cfg_idx_t;

    localparam int CFG_NUM = 8;
    localparam int CFG_IDX_W = 3;

    localparam len_t CFG_RESET [CFG_NUM] = '{
        len_t'(6), len_t'(64), len_t'(60), len_t'(10),
        len_t'(9), len_t'(55), len_t'(480), len_t'(70)
    };

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_PRE_HIGH   = 4'd1,
        PH_RST_LOW    = 4'd2,
        PH_RST_REL    = 4'd3,
        PH_RST_RECOV  = 4'd4,
        PH_SLOT_LOW   = 4'd5,
        PH_SLOT_HIGH  = 4'd6,
        PH_READ_RECOV = 4'd7
    } phase_t;

    typedef enum logic {
        ENG_RUN    = 1'b0,
        ENG_SETTLE = 1'b1
    } eng_mode_t;

    // one classified transaction waiting for the engine
    typedef struct packed {
        op_t   op;
        byte_t data;
        logic  level;
    } cmd_t;

    // one result transaction
    typedef struct packed {
        logic  drive_enable;
        logic  drive_value;
        logic  busy;
        logic  done;
        byte_t read_data;
        logic  presence;
        logic  rejected;
    } res_t;

    function automatic timer_t sat_len(input logic [SAT_W-1:0] len);
        if (len > SAT_W'(TIMER_MAX))
            return timer_t'(TIMER_MAX);
        else
            return timer_t'(len);
    endfunction

    function automatic logic is_read(input op_t op);
        return (op == OP_RBIT) || (op == OP_RBYTE);
    endfunction

endpackage

// ===== sv/owm_front.sv =====
`timescale 1ns / 1ps
// owm_front: takes input transactions, classifies the action and queues them
// depends on owm_pkg

module owm_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [2:0]           action,
    input  logic [7:0]           data_byte,
    input  logic                 bus_level,
    output logic                 cmd_valid,
    output owm_pkg::cmd_t        cmd,
    input  logic                 cmd_pop
);

    owm_pkg::cmd_t                      q_mem [owm_pkg::CMDQ_DEPTH];
    logic [owm_pkg::CMDQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [owm_pkg::CMDQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [owm_pkg::CMDQ_CNT_W-1:0]     cnt_reg, cnt_next;
    owm_pkg::op_t                       op_class;
    logic                               do_push;
    logic                               do_pop;

    // unknown actions count as plain ticks
    always_comb
    begin
        case (action)
            owm_pkg::OP_RESET: op_class = owm_pkg::OP_RESET;
            owm_pkg::OP_WBIT:  op_class = owm_pkg::OP_WBIT;
            owm_pkg::OP_RBIT:  op_class = owm_pkg::OP_RBIT;
            owm_pkg::OP_WBYTE: op_class = owm_pkg::OP_WBYTE;
            owm_pkg::OP_RBYTE: op_class = owm_pkg::OP_RBYTE;
            default:           op_class = owm_pkg::OP_TICK;
        endcase
    end

    assign full      = (cnt_reg == owm_pkg::CMDQ_CNT_W'(owm_pkg::CMDQ_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == owm_pkg::CMDQ_PTR_W'(owm_pkg::CMDQ_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == owm_pkg::CMDQ_PTR_W'(owm_pkg::CMDQ_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg].op    <= op_class;
            q_mem[wr_ptr_reg].data  <= data_byte;
            q_mem[wr_ptr_reg].level <= bus_level;
        end
    end

endmodule

// ===== sv/owm_engine.sv =====
`timescale 1ns / 1ps
// owm_engine: bus sequencer with slot timer, shift register and config registers
// depends on owm_pkg

module owm_engine
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [owm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owm_pkg::LEN_W-1:0]     cfg_data,
    input  logic                          cmd_valid,
    input  owm_pkg::cmd_t                 cmd,
    output logic                          cmd_pop,
    input  logic                          res_full,
    output logic                          res_push,
    output owm_pkg::res_t                 res
);

    owm_pkg::len_t       cfg_reg [owm_pkg::CFG_NUM];
    owm_pkg::eng_mode_t  mode_reg, mode_next;
    owm_pkg::phase_t     phase_reg, phase_next;
    owm_pkg::timer_t     cnt_reg, cnt_next;
    owm_pkg::byte_t      shift_reg, shift_next;
    owm_pkg::bits_t      bits_reg, bits_next;
    logic                pres_reg, pres_next;
    owm_pkg::op_t        op_reg, op_next;
    owm_pkg::byte_t      rdata_reg, rdata_next;
    logic                lvl_reg, lvl_next;
    logic                done_reg, done_next;
    logic                rej_reg, rej_next;
    logic                step_bit;

    function automatic owm_pkg::timer_t slot_low_len(input owm_pkg::op_t op,
                                                     input logic bit0,
                                                     input owm_pkg::len_t one_len,
                                                     input owm_pkg::len_t zero_len);
        if (owm_pkg::is_read(op) || bit0)
            return owm_pkg::sat_len(owm_pkg::SAT_W'(one_len));
        else
            return owm_pkg::sat_len(owm_pkg::SAT_W'(zero_len));
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        pres_next  = pres_reg;
        op_next    = op_reg;
        rdata_next = rdata_reg;
        lvl_next   = lvl_reg;
        done_next  = done_reg;
        rej_next   = rej_reg;
        step_bit   = 1'b0;
        cmd_pop    = 1'b0;
        res_push   = 1'b0;

        case (mode_reg)
            owm_pkg::ENG_RUN:
            begin
                if (cmd_valid && !res_full)
                begin
                    cmd_pop   = 1'b1;
                    lvl_next  = cmd.level;
                    done_next = 1'b0;
                    rej_next  = 1'b0;
                    if (phase_reg != owm_pkg::PH_IDLE)
                    begin
                        // busy: the command is dropped, the tick still counts
                        rej_next = (cmd.op != owm_pkg::OP_TICK);
                        if (cnt_reg != '0)
                            cnt_next = cnt_reg - 1'b1;
                    end
                    else if (cmd.op != owm_pkg::OP_TICK)
                    begin
                        op_next = cmd.op;
                        case (cmd.op)
                            owm_pkg::OP_RESET:
                            begin
                                phase_next = owm_pkg::PH_PRE_HIGH;
                            end
                            owm_pkg::OP_WBIT:
                            begin
                                shift_next = {{(owm_pkg::BYTE_W-1){1'b0}}, cmd.data[0]};
                                bits_next  = owm_pkg::bits_t'(1);
                            end
                            owm_pkg::OP_RBIT:
                            begin
                                shift_next = '0;
                                bits_next  = owm_pkg::bits_t'(1);
                            end
                            owm_pkg::OP_WBYTE:
                            begin
                                shift_next = cmd.data;
                                bits_next  = owm_pkg::BYTE_BITS;
                            end
                            default:
                            begin
                                shift_next = '0;
                                bits_next  = owm_pkg::BYTE_BITS;
                            end
                        endcase
                        if (cmd.op == owm_pkg::OP_RESET)
                            cnt_next = owm_pkg::sat_len(
                                owm_pkg::SAT_W'(owm_pkg::PRE_RESET_HIGH_TICKS));
                        else
                        begin
                            phase_next = owm_pkg::PH_SLOT_LOW;
                            cnt_next   = slot_low_len(cmd.op, shift_next[0],
                                                      cfg_reg[owm_pkg::CFG_W1_LOW],
                                                      cfg_reg[owm_pkg::CFG_W0_LOW]);
                        end
                    end
                    // expired phase: walk the zero-length phases one per cycle while the result queue has room
                    if ((phase_next != owm_pkg::PH_IDLE) && (cnt_next == '0))
                        mode_next = owm_pkg::ENG_SETTLE;
                    else
                        res_push = 1'b1;
                end
            end
            owm_pkg::ENG_SETTLE:
            begin
                if (!res_full)
                begin
                    case (phase_reg)
                        owm_pkg::PH_PRE_HIGH:
                        begin
                            phase_next = owm_pkg::PH_RST_LOW;
                            cnt_next   = owm_pkg::sat_len(
                                owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_RST_LOW]));
                        end
                        owm_pkg::PH_RST_LOW:
                        begin
                            phase_next = owm_pkg::PH_RST_REL;
                            cnt_next   = owm_pkg::sat_len(
                                owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_PRES_WAIT]));
                        end
                        owm_pkg::PH_RST_REL:
                        begin
                            // a device answers by holding the line low
                            pres_next  = !lvl_reg;
                            phase_next = owm_pkg::PH_RST_RECOV;
                            cnt_next   = owm_pkg::sat_len(
                                owm_pkg::SAT_W'(owm_pkg::RECOVERY_TICKS));
                        end
                        owm_pkg::PH_RST_RECOV:
                        begin
                            phase_next = owm_pkg::PH_IDLE;
                            cnt_next   = '0;
                            done_next  = 1'b1;
                        end
                        owm_pkg::PH_SLOT_LOW:
                        begin
                            phase_next = owm_pkg::PH_SLOT_HIGH;
                            if (owm_pkg::is_read(op_reg))
                                cnt_next = owm_pkg::sat_len(
                                    owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_RD_SAMPLE]));
                            else if (shift_reg[0])
                                cnt_next = owm_pkg::sat_len(
                                    owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_W1_HIGH]));
                            else
                                cnt_next = owm_pkg::sat_len(
                                    owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_W0_HIGH]));
                        end
                        owm_pkg::PH_SLOT_HIGH:
                        begin
                            if (owm_pkg::is_read(op_reg))
                            begin
                                shift_next = {lvl_reg, shift_reg[owm_pkg::BYTE_W-1:1]};
                                phase_next = owm_pkg::PH_READ_RECOV;
                                cnt_next   = owm_pkg::sat_len(
                                    owm_pkg::SAT_W'(cfg_reg[owm_pkg::CFG_RD_RECOV]));
                            end
                            else
                            begin
                                shift_next = {1'b0, shift_reg[owm_pkg::BYTE_W-1:1]};
                                step_bit   = 1'b1;
                            end
                        end
                        owm_pkg::PH_READ_RECOV:
                        begin
                            step_bit = 1'b1;
                        end
                        default:
                        begin
                            phase_next = owm_pkg::PH_IDLE;
                            cnt_next   = '0;
                        end
                    endcase

                    if (step_bit)
                    begin
                        bits_next = bits_reg - 1'b1;
                        if (bits_next != '0)
                        begin
                            phase_next = owm_pkg::PH_SLOT_LOW;
                            cnt_next   = slot_low_len(op_reg, shift_next[0],
                                                      cfg_reg[owm_pkg::CFG_W1_LOW],
                                                      cfg_reg[owm_pkg::CFG_W0_LOW]);
                        end
                        else
                        begin
                            if (op_reg == owm_pkg::OP_RBIT)
                                rdata_next = {{(owm_pkg::BYTE_W-1){1'b0}},
                                              shift_next[owm_pkg::BYTE_W-1]};
                            else if (op_reg == owm_pkg::OP_RBYTE)
                                rdata_next = shift_next;
                            phase_next = owm_pkg::PH_IDLE;
                            cnt_next   = '0;
                            done_next  = 1'b1;
                        end
                    end

                    if (!((phase_next != owm_pkg::PH_IDLE) && (cnt_next == '0)))
                    begin
                        res_push  = 1'b1;
                        mode_next = owm_pkg::ENG_RUN;
                    end
                end
            end
            default:
            begin
                mode_next = owm_pkg::ENG_RUN;
            end
        endcase
    end

    // result reflects the state after the transaction
    always_comb
    begin
        case (phase_next)
            owm_pkg::PH_PRE_HIGH, owm_pkg::PH_RST_REL, owm_pkg::PH_SLOT_HIGH:
            begin
                res.drive_enable = 1'b1;
                res.drive_value  = 1'b1;
            end
            owm_pkg::PH_RST_LOW, owm_pkg::PH_SLOT_LOW:
            begin
                res.drive_enable = 1'b1;
                res.drive_value  = 1'b0;
            end
            default:
            begin
                res.drive_enable = 1'b0;
                res.drive_value  = 1'b1;
            end
        endcase
        res.busy      = (phase_next != owm_pkg::PH_IDLE);
        res.done      = done_next;
        res.read_data = rdata_next;
        res.presence  = pres_next;
        res.rejected  = rej_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= owm_pkg::ENG_RUN;
            phase_reg <= owm_pkg::PH_IDLE;
            cnt_reg   <= '0;
            shift_reg <= '0;
            bits_reg  <= '0;
            pres_reg  <= 1'b0;
            op_reg    <= owm_pkg::OP_TICK;
            rdata_reg <= '0;
            lvl_reg   <= 1'b0;
            done_reg  <= 1'b0;
            rej_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            pres_reg  <= pres_next;
            op_reg    <= op_next;
            rdata_reg <= rdata_next;
            lvl_reg   <= lvl_next;
            done_reg  <= done_next;
            rej_reg   <= rej_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < owm_pkg::CFG_NUM; i++)
                cfg_reg[i] <= owm_pkg::CFG_RESET[i];
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

endmodule

// ===== sv/owm_resq.sv =====
`timescale 1ns / 1ps
// owm_resq: short result queue between the engine and the result ports
// depends on owm_pkg

module owm_resq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  owm_pkg::res_t  res_in,
    output logic           res_full,
    input  logic           pop,
    output logic           empty,
    output owm_pkg::res_t  res_out
);

    owm_pkg::res_t                      q_mem [owm_pkg::RESQ_DEPTH];
    logic [owm_pkg::RESQ_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [owm_pkg::RESQ_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [owm_pkg::RESQ_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                               do_push;
    logic                               do_pop;

    assign res_full = (cnt_reg == owm_pkg::RESQ_CNT_W'(owm_pkg::RESQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign res_out  = q_mem[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            if (wr_ptr_reg == owm_pkg::RESQ_PTR_W'(owm_pkg::RESQ_DEPTH - 1))
                wr_ptr_next = '0;
            else
                wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            if (rd_ptr_reg == owm_pkg::RESQ_PTR_W'(owm_pkg::RESQ_DEPTH - 1))
                rd_ptr_next = '0;
            else
                rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_mem[wr_ptr_reg] <= res_in;
    end

endmodule

// ===== sv/one_wire_bus_master_unit.sv =====
`timescale 1ns / 1ps
// one_wire_bus_master_unit: top level of the one-wire bus master
// depends on owm_pkg, owm_front, owm_engine, owm_resq
//
// channel   | handshake              | payload
// ----------+------------------------+---------------------------------------------
// input     | push / full            | action, data_byte, bus_level
// result    | empty / pop            | drive_enable, drive_value, busy_res, done_res,
//           |                        | read_data, presence, command_rejected
// config    | cfg_we                 | cfg_index, cfg_data
//
// one transaction a cycle while the result queue has room and no expired phase is
// walked; a result reaches the ports via the command queue and the result queue
// a transaction that ends a phase has the engine walk every expired phase it passes
// before the next is taken (up to 24 phases for a read byte with all timings zero)
// rst_n clears the queues, the sequencer and loads the default timings
// full and empty stall each side on its own; the two queues decouple the engine

module one_wire_bus_master_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [2:0] action,
    input  logic [7:0] data_byte,
    input  logic       bus_level,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_data,
    output logic       empty,
    input  logic       pop,
    output logic       drive_enable,
    output logic       drive_value,
    output logic       busy_res,
    output logic       done_res,
    output logic [7:0] read_data,
    output logic       presence,
    output logic       command_rejected
);

    logic           cmd_valid;
    owm_pkg::cmd_t  cmd;
    logic           cmd_pop;
    logic           res_full;
    logic           res_push;
    owm_pkg::res_t  res_in;
    owm_pkg::res_t  res_out;

    owm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .data_byte (data_byte),
        .bus_level (bus_level),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    owm_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    owm_resq u_resq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .pop      (pop),
        .empty    (empty),
        .res_out  (res_out)
    );

    assign drive_enable     = res_out.drive_enable;
    assign drive_value      = res_out.drive_value;
    assign busy_res         = res_out.busy;
    assign done_res         = res_out.done;
    assign read_data        = res_out.read_data;
    assign presence         = res_out.presence;
    assign command_rejected = res_out.rejected;

endmodule

// ===== sv/owm_checker.sv =====
`timescale 1ns / 1ps
// owm_checker: port-level assertions for the one-wire bus master
// bound to one_wire_bus_master_unit; no other dependencies

module owm_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic       drive_enable,
    input logic       drive_value,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] read_data,
    input logic       presence,
    input logic       command_rejected
);

    // a finished command leaves the bus idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && done_res) |-> !busy_res)
        else $error("done reported on a busy result");

    // an idle master never drives the line
    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !busy_res) |-> (!drive_enable && drive_value))
        else $error("line driven while idle");

    // a released line always reads as high on drive_value
    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !drive_enable) |-> drive_value)
        else $error("drive_value low while released");

    // a waiting result transaction is held until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(read_data) && $stable(done_res)
                              && $stable(presence) && $stable(command_rejected)))
        else $error("waiting result changed before pop");

endmodule

bind one_wire_bus_master_unit owm_checker u_owm_checker (.*);

// ===== tb/sv/owm_result_checker.sv =====
`timescale 1ns / 1ps
// owm_result_checker: works out the expected bus state after every input transaction
// of the one-wire bus master and compares it with each popped result
// depends on owm_pkg; watches the input, result and timing-write ports of the block

module owm_result_checker
    import owm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [2:0]  action,
    input  logic [7:0]  data_byte,
    input  logic        bus_level,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [9:0]  cfg_data,
    input  logic        empty,
    input  logic        pop,
    input  logic        drive_enable,
    input  logic        drive_value,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [7:0]  read_data,
    input  logic        presence,
    input  logic        command_rejected,
    output int unsigned mismatches,
    output int unsigned outstanding,
    output logic        seq_active
);

    // own copy of the timing registers and the sequencer
    len_t   timing [CFG_NUM];
    phase_t phase_q;
    timer_t ticks_q;
    byte_t  shift_q;
    bits_t  bits_q;
    logic   pres_q;
    op_t    op_q;
    byte_t  rd_q;

    res_t   expected_bus_states [$];

    task automatic restore_defaults();
        for (int i = 0; i < CFG_NUM; i++)
        begin
            timing[i] = CFG_RESET[i];
        end
        phase_q = PH_IDLE;
        ticks_q = '0;
        shift_q = '0;
        bits_q  = '0;
        pres_q  = 1'b0;
        op_q    = OP_TICK;
        rd_q    = '0;
    endtask

    task automatic enter_phase(input phase_t p, input int unsigned len);
        phase_q = p;
        ticks_q = (len > TIMER_MAX) ? timer_t'(TIMER_MAX) : timer_t'(len);
    endtask

    function automatic logic reading();
        return (op_q == OP_RBIT) || (op_q == OP_RBYTE);
    endfunction

    task automatic begin_slot();
        if (reading() || shift_q[0])
            enter_phase(PH_SLOT_LOW, timing[CFG_W1_LOW]);
        else
            enter_phase(PH_SLOT_LOW, timing[CFG_W0_LOW]);
    endtask

    task automatic finish_bit(output logic fin);
        bits_q = bits_q - 1'b1;
        fin = 1'b0;
        if (bits_q != 0)
        begin
            begin_slot();
        end
        else
        begin
            if (reading())
                rd_q = (op_q == OP_RBIT) ? {7'b0, shift_q[7]} : shift_q;
            enter_phase(PH_IDLE, 0);
            fin = 1'b1;
        end
    endtask

    // walk through every phase whose count has run out within this tick
    task automatic run_out_phases(input logic lvl, output logic fin);
        logic ended;
        fin = 1'b0;
        while (phase_q != PH_IDLE && ticks_q == 0)
        begin
            case (phase_q)
                PH_PRE_HIGH:  enter_phase(PH_RST_LOW, timing[CFG_RST_LOW]);
                PH_RST_LOW:   enter_phase(PH_RST_REL, timing[CFG_PRES_WAIT]);
                PH_RST_REL:
                begin
                    // a device answers by holding the line low
                    pres_q = ~lvl;
                    enter_phase(PH_RST_RECOV, RECOVERY_TICKS);
                end
                PH_RST_RECOV:
                begin
                    enter_phase(PH_IDLE, 0);
                    fin = 1'b1;
                end
                PH_SLOT_LOW:
                begin
                    if (reading())
                        enter_phase(PH_SLOT_HIGH, timing[CFG_RD_SAMPLE]);
                    else if (shift_q[0])
                        enter_phase(PH_SLOT_HIGH, timing[CFG_W1_HIGH]);
                    else
                        enter_phase(PH_SLOT_HIGH, timing[CFG_W0_HIGH]);
                end
                PH_SLOT_HIGH:
                begin
                    if (reading())
                    begin
                        shift_q = {lvl, shift_q[7:1]};
                        enter_phase(PH_READ_RECOV, timing[CFG_RD_RECOV]);
                    end
                    else
                    begin
                        shift_q = shift_q >> 1;
                        finish_bit(ended);
                        fin = ended;
                    end
                end
                PH_READ_RECOV:
                begin
                    finish_bit(ended);
                    fin = ended;
                end
                default:      enter_phase(PH_IDLE, 0);
            endcase
        end
    endtask

    task automatic advance_master(input logic [2:0] act, input byte_t d, input logic lvl,
                                  output res_t r);
        logic is_cmd;
        logic rej;
        logic fin;
        is_cmd = (act >= OP_RESET) && (act <= OP_RBYTE);
        rej = 1'b0;
        fin = 1'b0;
        if (phase_q != PH_IDLE)
        begin
            rej = is_cmd;
            if (ticks_q != 0)
                ticks_q = ticks_q - 1'b1;
            run_out_phases(lvl, fin);
        end
        else if (is_cmd)
        begin
            op_q = op_t'(act);
            case (op_q)
                OP_RESET: enter_phase(PH_PRE_HIGH, PRE_RESET_HIGH_TICKS);
                OP_WBIT:
                begin
                    shift_q = {7'b0, d[0]};
                    bits_q = 4'd1;
                    begin_slot();
                end
                OP_RBIT:
                begin
                    shift_q = '0;
                    bits_q = 4'd1;
                    begin_slot();
                end
                OP_WBYTE:
                begin
                    shift_q = d;
                    bits_q = 4'd8;
                    begin_slot();
                end
                default:
                begin
                    shift_q = '0;
                    bits_q = 4'd8;
                    begin_slot();
                end
            endcase
            run_out_phases(lvl, fin);
        end

        case (phase_q)
            PH_PRE_HIGH, PH_RST_REL, PH_SLOT_HIGH:
            begin
                r.drive_enable = 1'b1;
                r.drive_value  = 1'b1;
            end
            PH_RST_LOW, PH_SLOT_LOW:
            begin
                r.drive_enable = 1'b1;
                r.drive_value  = 1'b0;
            end
            default:
            begin
                // released line reads back as high
                r.drive_enable = 1'b0;
                r.drive_value  = 1'b1;
            end
        endcase
        r.busy      = (phase_q != PH_IDLE);
        r.done      = fin;
        r.read_data = rd_q;
        r.presence  = pres_q;
        r.rejected  = rej;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got;
        res_t want;
        res_t next_res;
        if (!rst_n)
        begin
            restore_defaults();
            expected_bus_states.delete();
            mismatches = 0;
            outstanding = 0;
            seq_active = 1'b0;
        end
        else
        begin
            if (cfg_we)
                timing[cfg_index] = cfg_data;

            if (pop && !empty)
            begin
                got = {drive_enable, drive_value, busy_res, done_res, read_data, presence,
                       command_rejected};
                if (expected_bus_states.size() == 0)
                begin
                    $error("result transaction with nothing expected: %h", got);
                    mismatches++;
                end
                else
                begin
                    want = expected_bus_states.pop_front();
                    check_field("drive_enable", want.drive_enable, got.drive_enable);
                    check_field("drive_value", want.drive_value, got.drive_value);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("presence", want.presence, got.presence);
                    check_field("command_rejected", want.rejected, got.rejected);
                end
            end

            if (push && !full)
            begin
                advance_master(action, data_byte, bus_level, next_res);
                expected_bus_states.push_back(next_res);
            end

            outstanding = expected_bus_states.size();
            seq_active = (phase_q != PH_IDLE);
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: stimulus and verdict for one_wire_bus_master_unit
// depends on owm_pkg, one_wire_bus_master_unit and owm_result_checker

module testbench;
    import owm_pkg::*;

    localparam logic [2:0] ACT_SPARE_A = 3'd6;
    localparam logic [2:0] ACT_SPARE_B = 3'd7;

    localparam int LVL_LOW  = 0;
    localparam int LVL_HIGH = 1;
    localparam int LVL_RAND = 2;

    localparam int TIMING_ZERO  = 0;
    localparam int TIMING_MAX   = 1;
    localparam int TIMING_SHORT = 2;

    localparam int RANDOM_ITEMS  = 250;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [2:0]  action;
    logic [7:0]  data_byte;
    logic        bus_level;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_data;
    logic        empty;
    logic        pop;
    logic        drive_enable;
    logic        drive_value;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_data;
    logic        presence;
    logic        command_rejected;

    int unsigned mismatches;
    int unsigned outstanding;
    logic        seq_active;

    int          burst_left;
    int unsigned items_sent;
    bit          drain_stuck;

    one_wire_bus_master_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .action           (action),
        .data_byte        (data_byte),
        .bus_level        (bus_level),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .empty            (empty),
        .pop              (pop),
        .drive_enable     (drive_enable),
        .drive_value      (drive_value),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_data        (read_data),
        .presence         (presence),
        .command_rejected (command_rejected)
    );

    owm_result_checker result_checker
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .action           (action),
        .data_byte        (data_byte),
        .bus_level        (bus_level),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .empty            (empty),
        .pop              (pop),
        .drive_enable     (drive_enable),
        .drive_value      (drive_value),
        .busy_res         (busy_res),
        .done_res         (done_res),
        .read_data        (read_data),
        .presence         (presence),
        .command_rejected (command_rejected),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .seq_active       (seq_active)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("one_wire_bus_master_unit verification failed");
        $finish;
    end

    // result side stalls on its own pattern, changing mode every so often
    initial
    begin
        int mode;
        int mode_left;
        pop = 1'b0;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       pop <= 1'b1;
                1:       pop <= 1'($urandom_range(0, 1));
                2:       pop <= ($urandom_range(0, 5) == 0);
                default: pop <= ((mode_left % 16) < 4);
            endcase
        end
    end

    function automatic logic pick_level(input int lvl_mode);
        if (lvl_mode == LVL_RAND)
            return 1'($urandom_range(0, 1));
        return (lvl_mode == LVL_HIGH);
    endfunction

    // one input transaction; the sender runs in bursts with gaps between them
    task automatic send_item(input logic [2:0] act, input byte_t d, input logic lvl);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        push      <= 1'b1;
        action    <= act;
        data_byte <= d;
        bus_level <= lvl;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // tick until the sequencer is idle, with the odd command thrown in while busy
    task automatic finish_command(input int lvl_mode, input int noise_pct);
        while (seq_active)
        begin
            if ($urandom_range(1, 100) <= noise_pct)
                send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          pick_level(lvl_mode));
            else
                send_item(OP_TICK, 8'($urandom_range(0, 255)), pick_level(lvl_mode));
        end
    endtask

    task automatic run_command(input op_t op, input byte_t d, input int lvl_mode,
                               input int noise_pct);
        send_item(op, d, pick_level(lvl_mode));
        finish_command(lvl_mode, noise_pct);
    endtask

    task automatic random_command(input int noise_pct);
        int pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0: run_command(OP_RESET, 8'($urandom_range(0, 255)), LVL_RAND, noise_pct);
            1: send_item(($urandom_range(0, 1) != 0) ? ACT_SPARE_A : ACT_SPARE_B,
                         8'($urandom_range(0, 255)), pick_level(LVL_RAND));
            2: send_item(OP_TICK, 8'($urandom_range(0, 255)), pick_level(LVL_RAND));
            3, 4, 5:
                run_command(OP_WBIT, 8'($urandom_range(0, 255)), LVL_RAND, noise_pct);
            6, 7, 8:
                run_command(OP_RBIT, 8'($urandom_range(0, 255)), LVL_RAND, noise_pct);
            9, 10, 11, 12:
                run_command(OP_WBYTE, 8'($urandom_range(0, 255)), LVL_RAND, noise_pct);
            default:
                run_command(OP_RBYTE, 8'($urandom_range(0, 255)), LVL_RAND, noise_pct);
        endcase
    endtask

    // let every expected result come out, then give the engine time to finish
    task automatic drain_results();
        int waited;
        waited = 0;
        push <= 1'b0;
        while (outstanding != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (outstanding != 0)
        begin
            $error("%0d result transactions never arrived", outstanding);
            drain_stuck = 1'b1;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_timings(input int setting);
        len_t plan [CFG_NUM];
        for (int i = 0; i < CFG_NUM; i++)
        begin
            case (setting)
                TIMING_ZERO: plan[i] = '0;
                TIMING_MAX:  plan[i] = '1;
                default:     plan[i] = ($urandom_range(0, 3) == 0) ? len_t'(0)
                                                               : len_t'($urandom_range(1, 14));
            endcase
        end
        for (int i = 0; i < CFG_NUM; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= plan[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned random_start;
        push        = 1'b0;
        action      = OP_TICK;
        data_byte   = '0;
        bus_level   = 1'b1;
        cfg_we      = 1'b0;
        cfg_index   = CFG_W1_LOW;
        cfg_data    = '0;
        rst_n       = 1'b0;
        burst_left  = 0;
        items_sent  = 0;
        drain_stuck = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, at the reset timings
        run_command(OP_WBIT, 8'h00, LVL_RAND, 0);
        run_command(OP_WBIT, 8'hFF, LVL_RAND, 0);
        run_command(OP_RBIT, 8'h00, LVL_LOW, 0);
        // commands arriving mid read bit are turned away
        send_item(OP_RBIT, 8'h3C, 1'b1);
        send_item(OP_WBIT, 8'h01, 1'b0);
        send_item(OP_RESET, 8'hFF, 1'b1);
        finish_command(LVL_HIGH, 0);
        send_item(ACT_SPARE_A, 8'h5A, 1'b0);
        send_item(ACT_SPARE_B, 8'hC3, 1'b1);
        send_item(OP_TICK, 8'hFF, 1'b0);
        drain_results();

        // zero-length phases collapse within a single tick
        program_timings(TIMING_ZERO);
        run_command(OP_RESET, 8'h00, LVL_LOW, 0);
        repeat (6) random_command(10);
        drain_results();

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            program_timings(TIMING_SHORT);
            repeat (4) random_command(6);
            drain_results();
        end

        if (mismatches == 0 && !drain_stuck)
            $display("one_wire_bus_master_unit verification clean");
        else
            $display("one_wire_bus_master_unit verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/owm_pkg.sv
sv/owm_front.sv
sv/owm_engine.sv
sv/owm_resq.sv
sv/one_wire_bus_master_unit.sv
sv/owm_checker.sv
tb/sv/owm_result_checker.sv
tb/sv/testbench.sv
